FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define PCS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define PCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/pcs_pkg.sv
// Package for the PID step block: widths, constants, register indexes, states.
// No dependencies.
`timescale 1ns / 1ps

package pcs_pkg;

  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int IN_W    = 16;
  localparam int ERR_W   = IN_W + 1;
  localparam int DIF_W   = ERR_W + 1;
  localparam int GAIN_W  = 32;
  localparam int SUM_W   = 32;
  localparam int DT_W    = 16;
  localparam int DRIVE_W = 16;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int HALF_W  = 32;
  localparam int HOLD_W  = 2 * HALF_W;
  localparam int ACC_W   = 82;

  localparam int DRIVE_FULL = 16384;
  localparam int SCALE_DIV  = 4000;
  localparam int SCALE_MUL  = 1000;
  localparam int ROUND_OFS  = SCALE_DIV / 2;
  localparam int DT_RESET   = 10;

  // divide by 4000 = shift by 5, then multiply by a reciprocal of 125
  localparam int DIV_SHIFT = 5;
  localparam int DIV_ODD   = SCALE_DIV >> DIV_SHIFT;
  localparam int QUO_W     = 15;
  localparam int REM_W     = 22;
  localparam int RECIP_SH  = 29;
  localparam int DIV_RECIP = ((1 << RECIP_SH) + DIV_ODD - 1) / DIV_ODD;

  localparam logic signed [ACC_W-1:0] CLAMP_HI = ACC_W'(DRIVE_FULL * SCALE_DIV);
  localparam logic signed [ACC_W-1:0] CLAMP_LO = ACC_W'(-(DRIVE_FULL * SCALE_DIV));

  typedef enum logic [1:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_DT
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_KP,
    ST_KI,
    ST_ILO,
    ST_IHI,
    ST_KD,
    ST_DLO,
    ST_DHI,
    ST_DACC,
    ST_RANGE,
    ST_DIV,
    ST_QUO,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/core/pid_controller_step_top.sv
// PID step block: config registers, shared 33x33 multiplier sequencer, reciprocal divide.
// Depends on pcs_pkg.
`timescale 1ns / 1ps

//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  kind, target, measured
//  out       output     out_valid/out_stall  drive
//  cfg       input      APB write/read       paddr, pwdata, prdata
//
// A sample holds in_stall high from its accept until its result leaves ST_DONE, so
// a new sample waits until the last is through: ST_SCALE to ST_DACC on the shared
// multiplier and accumulator, a range check, a reciprocal multiply by 1/125 on the
// same multiplier, a result state and an output state; a clamp skips ST_DIV, ST_QUO.
// A clear transaction zeroes the integral state and leaves the block idle.
// rst is synchronous; gains reset to 0, step time to 10, integral state to 0.
// A finished result waits in the output register; a new sample may be taken
// meanwhile, and its result waits until the previous one is taken.

module pid_controller_step_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pcs_pkg::ADDR_W-1:0]         paddr,
  input  logic [pcs_pkg::DATA_W-1:0]         pwdata,
  output logic [pcs_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic signed [pcs_pkg::IN_W-1:0]    target,
  input  logic signed [pcs_pkg::IN_W-1:0]    measured,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pcs_pkg::DRIVE_W-1:0] drive
);
  import pcs_pkg::*;

  state_t state, state_next;

  logic signed [GAIN_W-1:0]  gain_p, gain_i, gain_d;
  logic        [DT_W-1:0]    step_time;
  logic signed [SUM_W-1:0]   integral_sum;
  logic signed [ERR_W-1:0]   last_error;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIF_W-1:0]   dif;
  logic signed [PROD_W-1:0]  prod;
  logic signed [HOLD_W-1:0]  hold;
  logic signed [ACC_W-1:0]   acc;
  logic        [REM_W-1:0]   rem;
  logic signed [DRIVE_W-1:0] res;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [ACC_W-1:0]   acc_add;
  logic                      acc_en;
  logic                      hold_en;
  logic                      cfg_we;
  logic                      in_take;
  logic signed [ERR_W-1:0]   err_in;
  logic signed [ACC_W-1:0]   ofs;
  logic signed [SUM_W:0]     sum_ext;
  logic signed [SUM_W-1:0]   sum_sat;
  logic                      out_free;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_KP: prdata = gain_p;
      REG_KI: prdata = gain_i;
      REG_KD: prdata = gain_d;
      REG_DT: prdata = {{(DATA_W-DT_W){1'b0}}, step_time};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p    <= '0;
      gain_i    <= '0;
      gain_d    <= '0;
      step_time <= DT_W'(DT_RESET);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_KP: gain_p    <= pwdata;
        REG_KI: gain_i    <= pwdata;
        REG_KD: gain_d    <= pwdata;
        REG_DT: step_time <= pwdata[DT_W-1:0];
      endcase
    end
  end

  // handshake
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid & ~in_stall;
  assign out_free = ~(out_valid & out_stall);
  assign err_in   = ERR_W'(target) - ERR_W'(measured);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_take && !kind) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_KP;
      ST_KP:    state_next = ST_KI;
      ST_KI:    state_next = ST_ILO;
      ST_ILO:   state_next = ST_IHI;
      ST_IHI:   state_next = ST_KD;
      ST_KD:    state_next = ST_DLO;
      ST_DLO:   state_next = ST_DHI;
      ST_DHI:   state_next = ST_DACC;
      ST_DACC:  state_next = ST_RANGE;
      ST_RANGE: begin
        if (acc >= CLAMP_HI || acc < CLAMP_LO) state_next = ST_DONE;
        else state_next = ST_DIV;
      end
      ST_DIV:   state_next = ST_QUO;
      ST_QUO:   state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // multiplier operands and accumulator controls
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    acc_add = '0;
    acc_en  = 1'b0;
    hold_en = 1'b0;
    unique case (state)
      ST_SCALE: begin
        mul_a = MUL_W'(err);
        mul_b = MUL_W'(SCALE_MUL);
      end
      ST_KP: begin
        mul_a = MUL_W'(gain_p);
        mul_b = prod[MUL_W-1:0];
      end
      ST_KI: begin
        mul_a   = MUL_W'(gain_i);
        mul_b   = MUL_W'(integral_sum);
        acc_add = ACC_W'(prod);
        acc_en  = 1'b1;
      end
      ST_ILO, ST_DLO: begin
        mul_a   = {1'b0, prod[HALF_W-1:0]};
        mul_b   = {{(MUL_W-DT_W){1'b0}}, step_time};
        hold_en = 1'b1;
      end
      ST_IHI, ST_DHI: begin
        mul_a   = MUL_W'($signed(hold[HOLD_W-1:HALF_W]));
        mul_b   = {{(MUL_W-DT_W){1'b0}}, step_time};
        acc_add = ACC_W'(prod);
        acc_en  = 1'b1;
      end
      ST_KD: begin
        mul_a   = MUL_W'(gain_d);
        mul_b   = MUL_W'(dif);
        acc_add = ACC_W'(prod) <<< HALF_W;
        acc_en  = 1'b1;
      end
      ST_DACC: begin
        acc_add = ACC_W'(prod) <<< HALF_W;
        acc_en  = 1'b1;
      end
      ST_DIV: begin
        mul_a = {{(MUL_W-REM_W){1'b0}}, rem};
        mul_b = MUL_W'(DIV_RECIP);
      end
      default: begin
        acc_en = 1'b0;
      end
    endcase
  end

  assign ofs     = acc + CLAMP_HI;
  assign sum_ext = (SUM_W+1)'(integral_sum) + (SUM_W+1)'(err);

  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
      sum_sat = {sum_ext[SUM_W], {(SUM_W-1){~sum_ext[SUM_W]}}};
    else
      sum_sat = sum_ext[SUM_W-1:0];
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (hold_en) hold <= prod[HOLD_W-1:0];
    if (state == ST_KP) acc <= ACC_W'(ROUND_OFS);
    else if (acc_en) acc <= acc + acc_add;
    if (in_take && !kind) begin
      err <= err_in;
      dif <= DIF_W'(err_in) - DIF_W'(last_error);
    end
    unique case (state)
      ST_RANGE: begin
        if (acc >= CLAMP_HI) res <= DRIVE_W'(DRIVE_FULL);
        else if (acc < CLAMP_LO) res <= DRIVE_W'(-DRIVE_FULL);
        rem <= ofs[DIV_SHIFT +: REM_W];
      end
      ST_QUO: res <= DRIVE_W'({1'b0, prod[RECIP_SH +: QUO_W]}) - DRIVE_W'(DRIVE_FULL);
      default: begin
      end
    endcase
    if (state == ST_DONE && out_free) drive <= res;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      integral_sum <= '0;
      last_error   <= '0;
    end else begin
      state <= state_next;
      if (in_take && kind) integral_sum <= '0;
      if (state == ST_DONE && out_free) begin
        out_valid    <= 1'b1;
        last_error   <= err;
        integral_sum <= sum_sat;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/pcs_checker.sv
// Port-level checker for the PID step block, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               kind,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] drive
);

  `PCS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(drive), "stalled result changed")
  `PCS_ASSERT(a_drive_range, clk, rst, out_valid |-> (drive >= -16'sd16384 && drive <= 16'sd16384), "drive out of range")
  `PCS_ASSERT_NEXT(a_sample_busy, clk, rst, in_valid && !in_stall && !kind, in_stall, "sample did not occupy block")
  `PCS_ASSERT_NEXT(a_clear_ready, clk, rst, in_valid && !in_stall && kind, !in_stall, "clear left block busy")
  `PCS_ASSERT(a_out_after_work, clk, rst, $rose(out_valid) |-> $past(in_stall), "result without work")

endmodule

bind pid_controller_step_top pcs_checker u_pcs_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for pid_controller_step_top: directed table and
// randomized phases, each drive checked against a table value or a local predictor.
// Depends on pcs_pkg and the pid_controller_step_top RTL.
`timescale 1ns / 1ps

module tb_top;
  import pcs_pkg::*;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;
  localparam int   WIDE_W      = 96;
  localparam int   SETTLE_CYC  = 32;
  localparam int   TAIL_CYC    = 40;
  localparam int   WATCHDOG    = 2000;
  localparam int   RAND_PHASES = 7;
  localparam int   RAND_ITEMS  = 200;
  localparam longint SUM_MAX   = 2147483647;
  localparam longint SUM_MIN   = -SUM_MAX - 1;

  typedef struct {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [DT_W-1:0]   dt;
  } gain_set_t;

  typedef struct {
    int                        cfg;
    logic                      kind;
    logic signed [IN_W-1:0]    tgt;
    logic signed [IN_W-1:0]    meas;
    bit                        fixed;
    logic signed [DRIVE_W-1:0] drv;
  } dir_row_t;

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      in_valid;
  logic                      in_stall;
  logic                      kind;
  logic signed [IN_W-1:0]    target;
  logic signed [IN_W-1:0]    measured;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DRIVE_W-1:0] drive;

  // predictor copy of registers and loop state
  logic signed [GAIN_W-1:0]  sh_kp;
  logic signed [GAIN_W-1:0]  sh_ki;
  logic signed [GAIN_W-1:0]  sh_kd;
  logic [DT_W-1:0]           sh_dt;
  longint                    st_sum;
  longint                    st_last;

  logic signed [DRIVE_W-1:0] drive_q[$];
  logic signed [DRIVE_W-1:0] want;
  bit                        idle_en;
  int                        stall_left = 0;
  int                        quiet = 0;
  int                        fails = 0;
  int                        n_in = 0;
  int                        n_clear = 0;
  int                        n_out = 0;
  int                        n_writes = 0;

  gain_set_t gain_tab [0:7] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd10},
    '{32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000, 16'd10},
    '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 16'd10},
    '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'd0},
    '{32'h0000_0002, 32'h0000_0000, 32'h0000_0000, 16'd10},
    '{32'h0000_0004, 32'h0000_0000, 32'h0000_0000, 16'd10},
    '{32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 16'd1},
    '{32'h0000_1234, 32'h0002_0000, 32'hfffe_8000, 16'hffff}
  };

  // extremes, rounding ties, zero step time, clear handling
  dir_row_t dir_tab [0:24] = '{
    '{0, KIND_SAMPLE,  32767, -32768, 1'b1,      0},
    '{0, KIND_SAMPLE, -32768,  32767, 1'b1,      0},
    '{0, KIND_CLEAR,      -1,     -1, 1'b0,      0},
    '{0, KIND_SAMPLE,      0,      0, 1'b1,      0},
    '{1, KIND_SAMPLE,  32767, -32768, 1'b1,  16384},
    '{1, KIND_SAMPLE, -32768,  32767, 1'b1, -16384},
    '{1, KIND_SAMPLE,      5,      5, 1'b1,      0},
    '{2, KIND_SAMPLE,  32767, -32768, 1'b1, -16384},
    '{2, KIND_SAMPLE, -32768,  32767, 1'b1,  16384},
    '{3, KIND_SAMPLE,  32767, -32768, 1'b1,      0},
    '{3, KIND_SAMPLE, -32768,  32767, 1'b1,      0},
    '{4, KIND_SAMPLE,      1,      0, 1'b1,      1},
    '{4, KIND_SAMPLE,      0,      1, 1'b1,      0},
    '{5, KIND_SAMPLE,      1,      0, 1'b1,      1},
    '{5, KIND_SAMPLE,      0,      1, 1'b1,     -1},
    '{5, KIND_SAMPLE, -32768,  32767, 1'b1, -16384},
    '{6, KIND_SAMPLE,    100,      0, 1'b0,      0},
    '{6, KIND_SAMPLE,    200,     50, 1'b0,      0},
    '{6, KIND_CLEAR,   32767, -32768, 1'b0,      0},
    '{6, KIND_SAMPLE,    150,      0, 1'b0,      0},
    '{6, KIND_SAMPLE, -32768,  32767, 1'b0,      0},
    '{7, KIND_SAMPLE,   1000,  -1000, 1'b0,      0},
    '{7, KIND_CLEAR,       0,      0, 1'b0,      0},
    '{7, KIND_SAMPLE,     -7,     12, 1'b0,      0},
    '{7, KIND_SAMPLE,  32767,  32767, 1'b0,      0}
  };

  pid_controller_step_top u_top (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic step_model(input logic k, input logic signed [IN_W-1:0] t,
                            input logic signed [IN_W-1:0] m, output bit has,
                            output logic signed [DRIVE_W-1:0] d);
    longint err;
    longint dif;
    longint nsum;
    logic signed [WIDE_W-1:0] w_kp, w_ki, w_kd, w_e, w_d, w_s, w_dt, num, quo;
    has = 1'b0;
    d = '0;
    if (k == KIND_CLEAR) begin
      st_sum = 0;
    end else begin
      err = longint'(t) - longint'(m);
      dif = err - st_last;
      w_kp = sh_kp;
      w_ki = sh_ki;
      w_kd = sh_kd;
      w_e = err;
      w_d = dif;
      w_s = st_sum;
      w_dt = {{(WIDE_W-DT_W){1'b0}}, sh_dt};
      num = w_kp * w_e * SCALE_MUL + w_ki * w_s * w_dt + w_kd * w_d * w_dt + ROUND_OFS;
      if (num >= DRIVE_FULL * SCALE_DIV) begin
        quo = DRIVE_FULL;
      end else if (num < -(DRIVE_FULL * SCALE_DIV)) begin
        quo = -DRIVE_FULL;
      end else begin
        quo = num / SCALE_DIV;
        if ((num % SCALE_DIV) != 0 && num < 0) quo = quo - 1;
      end
      d = quo[DRIVE_W-1:0];
      has = 1'b1;
      st_last = err;
      nsum = st_sum + err;
      if (nsum > SUM_MAX) nsum = SUM_MAX;
      if (nsum < SUM_MIN) nsum = SUM_MIN;
      st_sum = nsum;
    end
  endtask

  task automatic send_txn(input logic k, input logic signed [IN_W-1:0] t,
                          input logic signed [IN_W-1:0] m, input bit fixed,
                          input logic signed [DRIVE_W-1:0] fixed_drive);
    bit has;
    logic signed [DRIVE_W-1:0] d;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    target <= t;
    measured <= m;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    step_model(k, t, m, has, d);
    if (has) drive_q.push_back(fixed ? fixed_drive : d);
    n_in++;
    if (k == KIND_CLEAR) n_clear++;
    @(posedge clk);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (drive_q.size() != 0);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] mask;
    mask = (idx == REG_DT) ? 32'h0000_ffff : 32'hffff_ffff;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    forever begin
      @(negedge clk);
      if (pready) break;
      @(posedge clk);
    end
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    forever begin
      @(negedge clk);
      if (pready) break;
      @(posedge clk);
    end
    if ((prdata & mask) !== (val & mask)) begin
      $error("prdata mismatch: expected %h, actual %h", val & mask, prdata & mask);
      fails++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  task automatic apply_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                             input logic [GAIN_W-1:0] kd, input logic [DT_W-1:0] dt);
    wait_results();
    repeat (SETTLE_CYC) @(posedge clk);
    reg_write(REG_KP, kp);
    reg_write(REG_KI, ki);
    reg_write(REG_KD, kd);
    reg_write(REG_DT, {16'd0, dt});
    sh_kp = kp;
    sh_ki = ki;
    sh_kd = kd;
    sh_dt = dt;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    logic [GAIN_W-1:0] g;
    int unsigned sh;
    case ($urandom_range(0, 5))
      0: g = $urandom;
      1: g = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: begin
        sh = $urandom_range(1, 16);
        g = $urandom & ((32'd1 << sh) - 32'd1);
        if ($urandom_range(0, 1)) g = -g;
      end
    endcase
    return g;
  endfunction

  function automatic logic [DT_W-1:0] pick_dt();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hffff;
      2: return DT_W'($urandom_range(1, 100));
      default: return DT_W'($urandom);
    endcase
  endfunction

  task automatic random_txn();
    logic k;
    logic signed [IN_W-1:0] t;
    logic signed [IN_W-1:0] m;
    int mm;
    k = ($urandom_range(0, 15) == 0) ? KIND_CLEAR : KIND_SAMPLE;
    t = IN_W'($urandom);
    if ($urandom_range(0, 1)) begin
      m = IN_W'($urandom);
    end else begin
      mm = int'(t) + int'($urandom_range(0, 200)) - 100;
      if (mm > 32767) mm = 32767;
      if (mm < -32768) mm = -32768;
      m = IN_W'(mm);
    end
    send_txn(k, t, m, 1'b0, '0);
  endtask

  // output side: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // drive checker and watchdog; a transaction seen here completes at the next edge
  always @(negedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (drive_q.size() == 0) begin
          $error("drive: no transaction expected, actual %0d", drive);
          fails++;
        end else begin
          want = drive_q.pop_front();
          if (drive !== want) begin
            $error("drive mismatch: expected %0d, actual %0d", want, drive);
            fails++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int ph;
    int cur;
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KIND_SAMPLE;
    target <= '0;
    measured <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sh_kp = '0;
    sh_ki = '0;
    sh_kd = '0;
    sh_dt = DT_RESET;
    st_sum = 0;
    st_last = 0;
    idle_en = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur = 0;
    for (i = 0; i < 25; i++) begin
      if (dir_tab[i].cfg != cur) begin
        cur = dir_tab[i].cfg;
        apply_gains(gain_tab[cur].kp, gain_tab[cur].ki, gain_tab[cur].kd, gain_tab[cur].dt);
      end
      send_txn(dir_tab[i].kind, dir_tab[i].tgt, dir_tab[i].meas, dir_tab[i].fixed,
               dir_tab[i].drv);
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      idle_en = (ph != 2) && (ph != RAND_PHASES - 1);
      apply_gains(pick_gain(), pick_gain(), pick_gain(), pick_dt());
      for (i = 0; i < RAND_ITEMS; i++) begin
        random_txn();
        if ($urandom_range(0, 99) == 0) wait_results();
      end
    end

    wait_results();
    repeat (TAIL_CYC) @(posedge clk);
    $display("Run: %0d input transactions (%0d clears), %0d drive results, %0d register writes",
             n_in, n_clear, n_out, n_writes);
    $display("Included gain and step-time extremes, rounding ties and random gain sets");
    if (fails == 0 && drive_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
